// ----- hw/rtl/lnp_pkg.sv -----
// ----------------------------------------------------------------------------
// lnp_pkg
// Shared widths, status codes and sideband type of the line crossing and
// nearest point block.
// ----------------------------------------------------------------------------
package lnp_pkg;

    // Quotient bits, divisor bits and dividend bits of the divider pipeline.
    localparam int DIV_QW = 33;
    localparam int DIV_DW = 32;
    localparam int DIV_NW = DIV_QW + DIV_DW;

    // Magnitude width of every dividend before the rounding offset.
    localparam int MAG_W = 52;

    // Number of divider lanes: factor a, factor b, point x, point y.
    localparam int LANES = 4;
    localparam int LANE_FA = 0;
    localparam int LANE_FB = 1;
    localparam int LANE_PX = 2;
    localparam int LANE_PY = 3;

    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_PAR = 2'd1;
    localparam logic [1:0] STAT_SAT = 2'd2;

    localparam logic signed [31:0] FACT_ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] FACT_HALF = 32'sh0000_8000;

    typedef struct packed {
        logic                mode;
        logic                den_zero;
        logic                clamp_lo;
        logic                clamp_hi;
        logic signed [15:0]  ax;
        logic signed [15:0]  ay;
        logic signed [16:0]  ex;
        logic signed [16:0]  ey;
        logic [LANES-1:0]    neg;
        logic [LANES-1:0]    ovf;
    } lnp_side_t;

endpackage

// ----- hw/rtl/lnp_div.sv -----
// ----------------------------------------------------------------------------
// lnp_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees that the top dividend bits are below the divisor.
// ----------------------------------------------------------------------------
module lnp_div #(
    parameter int QW = 33,
    parameter int DW = 32
) (
    input  logic                aclk,
    input  logic                en,
    input  logic [QW+DW-1:0]    n,
    input  logic [DW-1:0]       d,
    output logic [QW-1:0]       q
);
    import lnp_pkg::*;

    logic [DW-1:0] r_reg [0:QW];
    logic [QW-1:0] nl_reg [0:QW];
    logic [QW-1:0] q_reg [0:QW];
    logic [DW-1:0] d_reg [0:QW];

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]  <= n[QW+DW-1:QW];
            nl_reg[0] <= n[QW-1:0];
            q_reg[0]  <= '0;
            d_reg[0]  <= d;
            for (int k = 0; k < QW; k++) begin
                logic [DW:0] t;
                logic        ge;
                t  = {r_reg[k], nl_reg[k][QW-1]};
                ge = (t >= {1'b0, d_reg[k]});
                r_reg[k+1]  <= ge ? t[DW-1:0] - d_reg[k] : t[DW-1:0];
                q_reg[k+1]  <= {q_reg[k][QW-2:0], ge};
                nl_reg[k+1] <= {nl_reg[k][QW-2:0], 1'b0};
                d_reg[k+1]  <= d_reg[k];
            end
        end
    end

    assign q = q_reg[QW];

endmodule

// ----- hw/rtl/line_intersect_nearest_point.sv -----
// ----------------------------------------------------------------------------
// line_intersect_nearest_point
// Crossing point of two lines, or nearest point of a segment to a query
// point, with Q16.16 factors and rounded, saturated integer positions.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Fields (tdata, low bit up)                         tuser
// s_*       in   a_start_x a_start_y a_delta_x a_delta_y            req_type
//                b_start_x b_start_y b_delta_x b_delta_y
// m_*       out  point_x point_y factor_a factor_b status, 0 pad    -
//
// One request is taken per cycle while the output register is free; its
// result sits in the output register once the item has passed 40 register
// stages: five setup stages, the divider input stage, 33 divider stages that
// form one quotient bit each, and the output register.
// Reset (aresetn low, synchronous) clears every valid bit of the pipeline.
// When the result waits for m_tready the whole pipeline holds, so nothing
// is lost or repeated; s_tready follows the output stage.
//
module line_intersect_nearest_point (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // a_start_x, a_start_y, a_delta_x, a_delta_y,
    // b_start_x, b_start_y, b_delta_x, b_delta_y
    input  logic [127:0]  s_tdata,
    // req_type
    input  logic [0:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // point_x, point_y, factor_a, factor_b, status, then zero fill
    output logic [103:0]  m_tdata
);
    import lnp_pkg::*;

    // The whole pipeline moves as one when the output register is free.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Stage 1: capture and coordinate differences.
    logic               v1_reg, mode1;
    logic signed [15:0] ax1, ay1, sx1, sy1, tx1, ty1;
    logic signed [16:0] dx1, dyi1, dyn1;

    // Stage 2: products.
    logic               v2_reg, mode2;
    logic signed [15:0] ax2, ay2, sx2, sy2;
    logic signed [31:0] p0_2, p1_2;
    logic signed [32:0] m0_2, m1_2, m2_2, m3_2;

    // Stage 3: denominator and numerators.
    logic               v3_reg, mode3;
    logic signed [15:0] ax3, ay3, sx3, sy3;
    logic signed [32:0] den3;
    logic signed [33:0] fnum3, bnum3;

    // Stage 4: point numerator products and special case flags.
    logic               v4_reg, mode4, dz4, clo4, chi4;
    logic signed [15:0] ax4, ay4, sx4, sy4;
    logic signed [32:0] den4;
    logic signed [48:0] adx4, ady4;
    logic signed [49:0] nsx4, nsy4;
    logic signed [49:0] fan4, fbn4;

    // Stage 5: magnitudes and signs of the four dividends.
    logic               v5_reg, mode5, dz5, clo5, chi5;
    logic signed [15:0] ax5, ay5;
    logic signed [16:0] ex5, ey5;
    logic [MAG_W-1:0]   mag5 [LANES];
    logic [LANES-1:0]   neg5;
    logic [DIV_DW-1:0]  dabs5;

    always_ff @(posedge aclk) begin
        if (en) begin
            mode1 <= s_tuser[0];
            ax1   <= s_tdata[15:0];
            ay1   <= s_tdata[31:16];
            sx1   <= s_tdata[47:32];
            sy1   <= s_tdata[63:48];
            tx1   <= s_tdata[111:96];
            ty1   <= s_tdata[127:112];
            dx1   <= {s_tdata[79], s_tdata[79:64]} - {s_tdata[15], s_tdata[15:0]};
            dyi1  <= {s_tdata[31], s_tdata[31:16]} - {s_tdata[95], s_tdata[95:80]};
            dyn1  <= {s_tdata[95], s_tdata[95:80]} - {s_tdata[31], s_tdata[31:16]};

            mode2 <= mode1;
            ax2   <= ax1;
            ay2   <= ay1;
            sx2   <= sx1;
            sy2   <= sy1;
            p0_2  <= sx1 * (mode1 ? sx1 : ty1);
            p1_2  <= sy1 * (mode1 ? sy1 : tx1);
            m0_2  <= (mode1 ? sx1 : ty1) * dx1;
            m1_2  <= (mode1 ? sy1 : tx1) * (mode1 ? dyn1 : dyi1);
            m2_2  <= sy1 * dx1;
            m3_2  <= sx1 * dyi1;

            mode3 <= mode2;
            ax3   <= ax2;
            ay3   <= ay2;
            sx3   <= sx2;
            sy3   <= sy2;
            den3  <= mode2 ? ({p0_2[31], p0_2} + {p1_2[31], p1_2})
                           : ({p0_2[31], p0_2} - {p1_2[31], p1_2});
            fnum3 <= {m0_2[32], m0_2} + {m1_2[32], m1_2};
            bnum3 <= {m2_2[32], m2_2} + {m3_2[32], m3_2};

            mode4 <= mode3;
            ax4   <= ax3;
            ay4   <= ay3;
            sx4   <= sx3;
            sy4   <= sy3;
            den4  <= den3;
            dz4   <= (den3 == '0);
            clo4  <= mode3 && (fnum3 < 0);
            chi4  <= mode3 && (fnum3 > den3);
            adx4  <= ax3 * den3;
            ady4  <= ay3 * den3;
            nsx4  <= fnum3 * sx3;
            nsy4  <= fnum3 * sy3;
            fan4  <= {fnum3, 16'h0000};
            fbn4  <= {bnum3, 16'h0000};
        end
    end

    // Stage 5 registers: sign and magnitude of each dividend.
    always_ff @(posedge aclk) begin
        if (en) begin
            logic signed [MAG_W-1:0] nv [LANES];
            logic                    dneg;
            nv[LANE_FA] = MAG_W'(fan4);
            nv[LANE_FB] = MAG_W'(fbn4);
            nv[LANE_PX] = MAG_W'(adx4) + MAG_W'(nsx4);
            nv[LANE_PY] = MAG_W'(ady4) + MAG_W'(nsy4);
            dneg        = den4[32];
            for (int i = 0; i < LANES; i++) begin
                mag5[i] <= nv[i][MAG_W-1] ? MAG_W'(-nv[i]) : MAG_W'(nv[i]);
                neg5[i] <= nv[i][MAG_W-1] ^ dneg;
            end
            dabs5 <= dneg ? DIV_DW'(-den4) : DIV_DW'(den4);
            mode5 <= mode4;
            dz5   <= dz4;
            clo5  <= clo4;
            chi5  <= chi4;
            ax5   <= ax4;
            ay5   <= ay4;
            ex5   <= {ax4[15], ax4} + {sx4[15], sx4};
            ey5   <= {ay4[15], ay4} + {sy4[15], sy4};
        end
    end

    // Rounding offset, overflow check and divider lanes.
    logic [DIV_NW-1:0] nq [LANES];
    logic [DIV_QW-1:0] q  [LANES];
    logic [LANES-1:0]  ovf5;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic [MAG_W:0] sum;
        assign sum     = {1'b0, mag5[g]} + (MAG_W+1)'(dabs5 >> 1);
        assign nq[g]   = DIV_NW'(sum);
        assign ovf5[g] = (nq[g][DIV_NW-1:DIV_QW] >= dabs5);

        lnp_div #(
            .QW (DIV_QW),
            .DW (DIV_DW)
        ) u_div (
            .aclk (aclk),
            .en   (en),
            .n    (nq[g]),
            .d    (dabs5),
            .q    (q[g])
        );
    end

    // Sideband and valid bits travel alongside the dividers.
    lnp_side_t side5;
    lnp_side_t sd_reg [0:DIV_QW];
    logic      vd_reg [0:DIV_QW];

    always_comb begin
        side5.mode     = mode5;
        side5.den_zero = dz5;
        side5.clamp_lo = clo5;
        side5.clamp_hi = chi5;
        side5.ax       = ax5;
        side5.ay       = ay5;
        side5.ex       = ex5;
        side5.ey       = ey5;
        side5.neg      = neg5;
        side5.ovf      = ovf5;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0] <= side5;
            for (int k = 0; k < DIV_QW; k++) begin
                sd_reg[k+1] <= sd_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            for (int k = 0; k <= DIV_QW; k++) begin
                vd_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            vd_reg[0] <= v5_reg;
            for (int k = 0; k < DIV_QW; k++) begin
                vd_reg[k+1] <= vd_reg[k];
            end
        end
    end

    // Saturating sign application; the top bit of the result is the clip flag.
    function automatic logic [32:0] sat32(input logic [DIV_QW-1:0] m,
                                          input logic ovf, input logic neg);
        logic clip;
        logic [31:0] v;
        clip = ovf || (neg ? (m > 33'h1_0000_0000 >> 1) : (m > 33'h0_7FFF_FFFF));
        v    = neg ? -m[31:0] : m[31:0];
        if (clip) begin
            v = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return {clip, v};
    endfunction

    function automatic logic [16:0] sat16(input logic [DIV_QW-1:0] m,
                                          input logic ovf, input logic neg);
        logic clip;
        logic [15:0] v;
        clip = ovf || (neg ? (m > 33'd32768) : (m > 33'd32767));
        v    = neg ? -m[15:0] : m[15:0];
        if (clip) begin
            v = neg ? 16'h8000 : 16'h7FFF;
        end
        return {clip, v};
    endfunction

    function automatic logic [16:0] clip17(input logic signed [16:0] e);
        logic clip;
        logic [15:0] v;
        clip = (e > 17'sd32767) || (e < -17'sd32768);
        v    = e[15:0];
        if (clip) begin
            v = e[16] ? 16'h8000 : 16'h7FFF;
        end
        return {clip, v};
    endfunction

    // Output stage.
    logic        m_tvalid_reg;
    logic [15:0] px_reg, px_next, py_reg, py_next;
    logic [31:0] fa_reg, fa_next, fb_reg, fb_next;
    logic [1:0]  st_reg, st_next;

    always_comb begin
        lnp_side_t   sd;
        logic [32:0] sfa, sfb;
        logic [16:0] spx, spy, sex, sey;
        sd  = sd_reg[DIV_QW];
        sfa = sat32(q[LANE_FA], sd.ovf[LANE_FA], sd.neg[LANE_FA]);
        sfb = sat32(q[LANE_FB], sd.ovf[LANE_FB], sd.neg[LANE_FB]);
        spx = sat16(q[LANE_PX], sd.ovf[LANE_PX], sd.neg[LANE_PX]);
        spy = sat16(q[LANE_PY], sd.ovf[LANE_PY], sd.neg[LANE_PY]);
        sex = clip17(sd.ex);
        sey = clip17(sd.ey);
        if (sd.den_zero) begin
            // Parallel lines or a zero-length segment.
            px_next = sd.ax;
            py_next = sd.ay;
            fa_next = sd.mode ? FACT_HALF : '0;
            fb_next = '0;
            st_next = STAT_PAR;
        end else if (sd.clamp_lo) begin
            // Projection falls before the segment start.
            px_next = sd.ax;
            py_next = sd.ay;
            fa_next = '0;
            fb_next = '0;
            st_next = STAT_OK;
        end else if (sd.clamp_hi) begin
            // Projection falls beyond the segment end.
            px_next = sex[15:0];
            py_next = sey[15:0];
            fa_next = FACT_ONE;
            fb_next = '0;
            st_next = (sex[16] || sey[16]) ? STAT_SAT : STAT_OK;
        end else begin
            px_next = spx[15:0];
            py_next = spy[15:0];
            fa_next = sfa[31:0];
            fb_next = sd.mode ? '0 : sfb[31:0];
            st_next = (spx[16] || spy[16] || sfa[32] || (!sd.mode && sfb[32]))
                      ? STAT_SAT : STAT_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vd_reg[DIV_QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= px_next;
            py_reg <= py_next;
            fa_reg <= fa_next;
            fb_reg <= fb_next;
            st_reg <= st_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, st_reg, fb_reg, fa_reg, py_reg, px_reg};

`ifndef SYNTHESIS
    // A finished item in the last divider stage reaches the output register.
    a_pipe_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && vd_reg[DIV_QW]) |=> m_tvalid)
        else $error("pipeline item did not reach the output stage");

    // While the output stalls, the pipeline holds its items.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!en) |=> ($stable(vd_reg[DIV_QW]) && $stable(v5_reg)))
        else $error("pipeline moved during a stall");

    // Parallel status always comes with a zero second factor.
    a_par_fb: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[97:96] == STAT_PAR) |-> (m_tdata[95:64] == '0))
        else $error("parallel result with nonzero factor_b");
`endif

endmodule
